// ===== design/bst_pkg.sv =====
// Shared types and defaults for the byte stream tokenizer.
// Token and queue-entry layouts used by the front, the queue and the back.
package bst_pkg;

    localparam int BST_COLUMN_BITS = 16;
    localparam int BST_QUEUE_DEPTH = 4;

    // Token kinds as reported; CLS_SPACE is a byte class only and never leaves the front.
    typedef enum logic [2:0] {
        CLS_NUMBER  = 3'd0,
        CLS_STRING  = 3'd1,
        CLS_IDENT   = 3'd2,
        CLS_OP      = 3'd3,
        CLS_SEP     = 3'd4,
        CLS_INVALID = 3'd5,
        CLS_SPACE   = 3'd6
    } t_class;

    typedef struct packed {
        t_class      kind;
        logic [15:0] column;
        logic [15:0] length;
        logic [7:0]  first_char;
        logic        ends_instruction;
    } t_tok;

    // One accepted byte yields at most one entry; it holds two tokens when a pending
    // token closes on a byte that is itself a one-byte token.
    typedef struct packed {
        logic two;
        t_tok tok0;
        t_tok tok1;
    } t_entry;

endpackage

// ===== design/byte_stream_tokenizer.sv =====
// Byte stream tokenizer, top level: front classifier, entry queue, output back end.
// Depends on bst_pkg, bst_front, bst_queue and bst_back.
//
// Takes one source byte per cycle and reports tokens (numbers, strings,
// identifiers, operators, separators, invalid bytes) on the output stream.
// The input accepts a byte every cycle while the four-entry token queue has
// room; a byte that closes a pending number or identifier and is itself a
// one-byte token gives two tokens, which the output port sends one after the
// other, so while the receiver is ready sustained throughput is one byte per
// cycle except that each such byte takes an extra output slot. An accepted
// byte's first token passes through the entry queue and the output register.
// Token positions count bytes modulo 2**COLUMN_BITS and are reported in their
// low 16 bits; the line number written through the configuration port is
// stamped on each token and should be changed only while no tokens are in flight.
module byte_stream_tokenizer #(
    parameter int COLUMN_BITS = bst_pkg::BST_COLUMN_BITS,
    parameter int QUEUE_DEPTH = bst_pkg::BST_QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] char_in
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata,   // [15:0] column, [31:16] length,
                                        // [39:32] first_char, [55:40] line
    output logic [3:0]  m_axis_tuser,   // [2:0] kind, [3] ends_instruction
    output logic        m_axis_tlast    // last token caused by one byte
);
    import bst_pkg::*;

    logic        push, q_full, q_valid, q_pop;
    t_entry      push_entry, head_entry;
    t_tok        out_tok;
    logic [15:0] out_line;

    bst_front #(
        .COLUMN_BITS(COLUMN_BITS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .i_char  (s_axis_tdata),
        .i_full  (q_full),
        .o_ready (s_axis_tready),
        .o_push  (push),
        .o_entry (push_entry)
    );

    bst_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (push_entry),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_entry (head_entry)
    );

    bst_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_q_valid   (q_valid),
        .i_q_entry   (head_entry),
        .o_q_pop     (q_pop),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_out_tok   (out_tok),
        .o_out_line  (out_line),
        .o_out_last  (m_axis_tlast)
    );

    assign m_axis_tdata = {out_line, out_tok.first_char, out_tok.length, out_tok.column};
    assign m_axis_tuser = {out_tok.ends_instruction, out_tok.kind};

endmodule

// ===== design/bst_front.sv =====
// Front of the tokenizer: classifies each byte and tracks the pending token.
// Uses bst_pkg; pushes finished tokens into bst_queue.
module bst_front #(
    parameter int COLUMN_BITS = bst_pkg::BST_COLUMN_BITS
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  logic [7:0]      i_char,
    input  logic            i_full,
    output logic            o_ready,
    output logic            o_push,
    output bst_pkg::t_entry o_entry
);
    import bst_pkg::*;

    typedef enum logic [1:0] {
        MODE_IDLE   = 2'd0,
        MODE_NUMBER = 2'd1,
        MODE_IDENT  = 2'd2,
        MODE_STRING = 2'd3
    } t_mode;

    localparam logic [7:0] CHAR_TAB    = 8'd9;
    localparam logic [7:0] CHAR_NL     = 8'd10;
    localparam logic [7:0] CHAR_SPACE  = 8'd32;
    localparam logic [7:0] CHAR_QUOTE  = 8'd34;
    localparam logic [7:0] CHAR_LPAREN = 8'd40;
    localparam logic [7:0] CHAR_RPAREN = 8'd41;
    localparam logic [7:0] CHAR_DOT    = 8'd46;
    localparam logic [7:0] CHAR_ZERO   = 8'd48;
    localparam logic [7:0] CHAR_NINE   = 8'd57;
    localparam logic [7:0] CHAR_SEMI   = 8'd59;
    localparam logic [7:0] CHAR_UP_A   = 8'd65;
    localparam logic [7:0] CHAR_UP_Z   = 8'd90;
    localparam logic [7:0] CHAR_LOW_A  = 8'd97;
    localparam logic [7:0] CHAR_LOW_Z  = 8'd122;
    localparam logic [7:0] OP_CHARS [8] = '{8'd37, 8'd42, 8'd43, 8'd45,
                                            8'd47, 8'd60, 8'd61, 8'd62};

    function automatic t_class classify(input logic [7:0] c);
        logic is_op;
        is_op = 1'b0;
        for (int i = 0; i < 8; i++) begin
            if (c == OP_CHARS[i]) is_op = 1'b1;
        end
        priority if (c == CHAR_DOT || (c >= CHAR_ZERO && c <= CHAR_NINE))
            return CLS_NUMBER;
        else if (c == CHAR_QUOTE)
            return CLS_STRING;
        else if ((c >= CHAR_UP_A && c <= CHAR_UP_Z) || (c >= CHAR_LOW_A && c <= CHAR_LOW_Z))
            return CLS_IDENT;
        else if (is_op)
            return CLS_OP;
        else if (c == CHAR_LPAREN || c == CHAR_RPAREN || c == CHAR_SEMI)
            return CLS_SEP;
        else if (c == CHAR_SPACE || c == CHAR_TAB || c == CHAR_NL)
            return CLS_SPACE;
        else
            return CLS_INVALID;
    endfunction

    t_mode                  r_mode, n_mode;
    logic [COLUMN_BITS-1:0] r_col;
    logic [15:0]            r_start, n_start;
    logic [15:0]            r_len, n_len;
    logic [7:0]             r_first, n_first;

    logic        accept;
    t_class      cls;
    logic [15:0] pos16;
    logic [15:0] len_sat;
    logic        emit_pend, emit_one, emit_str;
    t_tok        tok_pend, tok_one, tok_str;

    assign o_ready = !i_full;
    assign accept  = i_valid && o_ready;
    assign cls     = classify(i_char);
    assign pos16   = 16'(r_col);
    assign len_sat = (r_len == 16'hFFFF) ? r_len : r_len + 16'd1;

    always_comb begin
        n_mode    = r_mode;
        n_start   = r_start;
        n_len     = r_len;
        n_first   = r_first;
        emit_pend = 1'b0;
        emit_one  = 1'b0;
        emit_str  = 1'b0;

        tok_pend.kind             = (r_mode == MODE_NUMBER) ? CLS_NUMBER : CLS_IDENT;
        tok_pend.column           = r_start;
        tok_pend.length           = r_len;
        tok_pend.first_char       = r_first;
        tok_pend.ends_instruction = 1'b0;

        tok_str.kind             = CLS_STRING;
        tok_str.column           = r_start;
        tok_str.length           = r_len;
        tok_str.first_char       = (r_len == 16'd0) ? 8'd0 : r_first;
        tok_str.ends_instruction = 1'b0;

        tok_one.kind             = cls;
        tok_one.column           = pos16;
        tok_one.length           = 16'd1;
        tok_one.first_char       = i_char;
        tok_one.ends_instruction = (cls == CLS_INVALID) || (i_char == CHAR_SEMI);

        if (r_mode == MODE_STRING) begin
            if (i_char == CHAR_QUOTE) begin
                emit_str = 1'b1;
                n_mode   = MODE_IDLE;
            end else begin
                if (r_len == 16'd0) n_first = i_char;
                n_len = len_sat;
            end
        end else if ((r_mode == MODE_NUMBER && cls == CLS_NUMBER) ||
                     (r_mode == MODE_IDENT && cls == CLS_IDENT)) begin
            n_len = len_sat;
        end else begin
            // close any pending number or identifier, then handle this byte
            emit_pend = (r_mode == MODE_NUMBER) || (r_mode == MODE_IDENT);
            n_mode    = MODE_IDLE;
            unique case (cls)
                CLS_NUMBER: begin
                    n_mode  = MODE_NUMBER;
                    n_start = pos16;
                    n_len   = 16'd1;
                    n_first = i_char;
                end
                CLS_IDENT: begin
                    n_mode  = MODE_IDENT;
                    n_start = pos16;
                    n_len   = 16'd1;
                    n_first = i_char;
                end
                CLS_STRING: begin
                    n_mode  = MODE_STRING;
                    n_start = pos16;
                    n_len   = 16'd0;
                    n_first = 8'd0;
                end
                CLS_OP, CLS_SEP, CLS_INVALID: begin
                    emit_one = 1'b1;
                end
                default: begin
                end
            endcase
        end

        o_entry.two  = emit_pend && emit_one;
        o_entry.tok0 = emit_str ? tok_str : (emit_pend ? tok_pend : tok_one);
        o_entry.tok1 = tok_one;
        o_push       = accept && (emit_str || emit_pend || emit_one);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_IDLE;
            r_col   <= '0;
            r_start <= '0;
            r_len   <= '0;
            r_first <= '0;
        end else if (accept) begin
            r_mode  <= n_mode;
            r_col   <= r_col + COLUMN_BITS'(1);
            r_start <= n_start;
            r_len   <= n_len;
            r_first <= n_first;
        end
    end

endmodule

// ===== design/bst_queue.sv =====
// Short queue of token entries between the front and the back.
// Uses bst_pkg entry type; holds entries in flops, read at the head pointer.
module bst_queue #(
    parameter int DEPTH = bst_pkg::BST_QUEUE_DEPTH
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  bst_pkg::t_entry i_entry,
    input  logic            i_pop,
    output logic            o_full,
    output logic            o_valid,
    output bst_pkg::t_entry o_entry
);
    import bst_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_entry           r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    logic do_push, do_pop;

    assign o_full   = (r_count == CNT_W'(DEPTH));
    assign o_valid  = (r_count != '0);
    assign o_entry  = r_mem[r_rd_ptr];
    assign do_push  = i_push && !o_full;
    assign do_pop   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wr_ptr] <= i_entry;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push)
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
            if (do_pop)
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
            if (do_push && !do_pop)
                r_count <= r_count + CNT_W'(1);
            else if (do_pop && !do_push)
                r_count <= r_count - CNT_W'(1);
        end
    end

endmodule

// ===== design/bst_back.sv =====
// Back of the tokenizer: unpacks queue entries into single tokens and drives
// the registered output stream. Holds the line number register. Uses bst_pkg.
module bst_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_we,
    input  logic [15:0]     i_cfg_wdata,
    input  logic            i_q_valid,
    input  bst_pkg::t_entry i_q_entry,
    output logic            o_q_pop,
    input  logic            i_out_ready,
    output logic            o_out_valid,
    output bst_pkg::t_tok   o_out_tok,
    output logic [15:0]     o_out_line,
    output logic            o_out_last
);
    import bst_pkg::*;

    logic [15:0] r_line_number;
    logic        r_half;
    logic        r_valid;
    t_tok        r_tok;
    logic [15:0] r_line;
    logic        r_last;

    logic load, take, cur_last;
    t_tok cur_tok;

    assign load     = !r_valid || i_out_ready;
    assign take     = load && i_q_valid;
    assign cur_tok  = r_half ? i_q_entry.tok1 : i_q_entry.tok0;
    assign cur_last = r_half || !i_q_entry.two;
    assign o_q_pop  = take && cur_last;

    assign o_out_valid = r_valid;
    assign o_out_tok   = r_tok;
    assign o_out_line  = r_line;
    assign o_out_last  = r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_number <= '0;
        end else if (i_cfg_we) begin
            r_line_number <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_half  <= 1'b0;
        end else if (take) begin
            r_valid <= 1'b1;
            // advance to the second token of a pair, or on to the next entry
            r_half  <= !cur_last;
        end else if (load) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_tok  <= cur_tok;
            r_line <= r_line_number;
            r_last <= cur_last;
        end
    end

endmodule

// ===== sim/byte_stream_tokenizer_tb.sv =====
// Testbench for byte_stream_tokenizer: streams text bytes in and checks every token out
// against a tokenizer predictor kept in step with the accepted bytes.
// Depends on bst_pkg and the byte_stream_tokenizer RTL.
module byte_stream_tokenizer_tb;
    import bst_pkg::*;

    localparam logic [7:0] CH_QUOTE   = 8'd34;
    localparam logic [7:0] CH_LPAREN  = 8'd40;
    localparam logic [7:0] CH_RPAREN  = 8'd41;
    localparam logic [7:0] CH_DOT     = 8'd46;
    localparam logic [7:0] CH_ZERO    = 8'd48;
    localparam logic [7:0] CH_NINE    = 8'd57;
    localparam logic [7:0] CH_SEMI    = 8'd59;
    localparam logic [7:0] CH_UPPER_A = 8'd65;
    localparam logic [7:0] CH_UPPER_Z = 8'd90;
    localparam logic [7:0] CH_LOWER_A = 8'd97;
    localparam logic [7:0] CH_LOWER_Z = 8'd122;
    localparam logic [7:0] CH_SPACE   = 8'd32;
    localparam logic [7:0] CH_TAB     = 8'd9;
    localparam logic [7:0] CH_NEWLINE = 8'd10;
    localparam logic [63:0] OP_CHARS  = {8'd62, 8'd61, 8'd60, 8'd47, 8'd45, 8'd43, 8'd42, 8'd37};
    localparam logic [23:0] SEP_CHARS = {CH_SEMI, CH_RPAREN, CH_LPAREN};
    localparam logic [23:0] WS_CHARS  = {CH_NEWLINE, CH_TAB, CH_SPACE};
    localparam int          DRAIN_CYCLES = 8;
    localparam int          LONG_TOKEN   = 200;
    localparam int          RANDOM_ITEMS = 1250;

    typedef enum logic [1:0] {LEX_IDLE, LEX_NUMBER, LEX_IDENT, LEX_STRING} t_lex_mode;

    typedef struct packed {
        t_class      kind;
        logic [15:0] column;
        logic [15:0] length;
        logic [7:0]  first_char;
        logic [15:0] line;
        logic        ends_instruction;
        logic        last;
    } t_token;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [15:0] i_cfg_wdata;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;   // [7:0] char_in
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [55:0] m_axis_tdata;   // [15:0] column, [31:16] length, [39:32] first_char,
                                 // [55:40] line
    logic [3:0]  m_axis_tuser;   // [2:0] kind, [3] ends_instruction
    logic        m_axis_tlast;

    // Tokenizer state as the predictor sees it
    t_lex_mode   lex_mode   = LEX_IDLE;
    logic [15:0] lex_column = '0;
    logic [15:0] lex_start  = '0;
    logic [15:0] lex_len    = '0;
    logic [7:0]  lex_first  = '0;
    logic [15:0] line_reg   = '0;

    t_token      expected_tokens[$];
    int          mismatches = 0;
    int          sent_items = 0;
    bit          no_idle = 1'b0;
    int          rx_hold = 0;
    int          rx_stall = 0;

    byte_stream_tokenizer uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #1 i_clk = ~i_clk;

    function automatic t_class byte_class(input logic [7:0] c);
        if (c == CH_DOT || (c >= CH_ZERO && c <= CH_NINE)) return CLS_NUMBER;
        if (c == CH_QUOTE) return CLS_STRING;
        if ((c >= CH_UPPER_A && c <= CH_UPPER_Z) || (c >= CH_LOWER_A && c <= CH_LOWER_Z))
            return CLS_IDENT;
        for (int i = 0; i < 8; i++)
            if (c == OP_CHARS[8*i +: 8]) return CLS_OP;
        for (int i = 0; i < 3; i++) begin
            if (c == SEP_CHARS[8*i +: 8]) return CLS_SEP;
            if (c == WS_CHARS[8*i +: 8]) return CLS_SPACE;
        end
        return CLS_INVALID;
    endfunction

    function automatic t_token make_token(input t_class kind, input logic [15:0] col,
                                          input logic [15:0] len, input logic [7:0] first,
                                          input logic ends);
        t_token t;
        t.kind             = kind;
        t.column           = col;
        t.length           = len;
        t.first_char       = first;
        t.line             = line_reg;
        t.ends_instruction = ends;
        t.last             = 1'b0;
        return t;
    endfunction

    // Advance the tokenizer by one byte and queue the tokens it reports
    task automatic tokenize_byte(input logic [7:0] c);
        t_class      cls;
        t_class      pending;
        logic [15:0] pos;
        t_token      toks[2];
        int          n;
        bit          extended;
        cls      = byte_class(c);
        pos      = lex_column;
        n        = 0;
        extended = 1'b0;
        lex_column = lex_column + 16'd1;
        if (lex_mode == LEX_STRING) begin
            if (c == CH_QUOTE) begin
                toks[n] = make_token(CLS_STRING, lex_start, lex_len,
                                     (lex_len == 0) ? 8'd0 : lex_first, 1'b0);
                n++;
                lex_mode = LEX_IDLE;
            end else begin
                if (lex_len == 0) lex_first = c;
                if (lex_len != 16'hFFFF) lex_len = lex_len + 16'd1;
            end
        end else begin
            if (lex_mode == LEX_NUMBER || lex_mode == LEX_IDENT) begin
                pending = (lex_mode == LEX_NUMBER) ? CLS_NUMBER : CLS_IDENT;
                if (cls == pending) begin
                    extended = 1'b1;
                    if (lex_len != 16'hFFFF) lex_len = lex_len + 16'd1;
                end else begin
                    toks[n] = make_token(pending, lex_start, lex_len, lex_first, 1'b0);
                    n++;
                    lex_mode = LEX_IDLE;
                end
            end
            if (!extended) begin
                case (cls)
                    CLS_NUMBER, CLS_IDENT, CLS_STRING: begin
                        lex_mode  = (cls == CLS_NUMBER) ? LEX_NUMBER :
                                    (cls == CLS_IDENT)  ? LEX_IDENT  : LEX_STRING;
                        lex_start = pos;
                        lex_len   = (cls == CLS_STRING) ? 16'd0 : 16'd1;
                        lex_first = (cls == CLS_STRING) ? 8'd0 : c;
                    end
                    CLS_OP: begin
                        toks[n] = make_token(CLS_OP, pos, 16'd1, c, 1'b0);
                        n++;
                    end
                    CLS_SEP: begin
                        toks[n] = make_token(CLS_SEP, pos, 16'd1, c, c == CH_SEMI);
                        n++;
                    end
                    CLS_INVALID: begin
                        toks[n] = make_token(CLS_INVALID, pos, 16'd1, c, 1'b1);
                        n++;
                    end
                    default: ;
                endcase
            end
        end
        for (int i = 0; i < n; i++) begin
            toks[i].last = (i == n - 1);
            expected_tokens = {expected_tokens, toks[i]};
        end
    endtask

    task automatic check_field(input string field, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", field, want, got);
            mismatches++;
        end
    endtask

    task automatic check_token();
        t_token want;
        if (expected_tokens.size() == 0) begin
            $error("token with none expected: tdata %h tuser %h", m_axis_tdata, m_axis_tuser);
            mismatches++;
        end else begin
            want = expected_tokens.pop_front();
            check_field("kind", want.kind, m_axis_tuser[2:0]);
            check_field("column", want.column, m_axis_tdata[15:0]);
            check_field("length", want.length, m_axis_tdata[31:16]);
            check_field("first_char", want.first_char, m_axis_tdata[39:32]);
            check_field("line", want.line, m_axis_tdata[55:40]);
            check_field("ends_instruction", want.ends_instruction, m_axis_tuser[3]);
            check_field("last", want.last, m_axis_tlast);
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            check_token();
            rx_stall = no_idle ? 0 : $urandom_range(0, 7);
        end
    end

    // Receiver: a long hold-off takes priority over the per-item stall
    always @(negedge i_clk) begin
        if (rx_hold > 0) begin
            m_axis_tready <= 1'b0;
            rx_hold--;
        end else if (rx_stall > 0) begin
            m_axis_tready <= 1'b0;
            rx_stall--;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    task automatic send_byte(input logic [7:0] c);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 7);
        @(negedge i_clk);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= c;
        do @(posedge i_clk); while (!s_axis_tready);
        tokenize_byte(c);
        sent_items++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_byte(s[i]);
    endtask

    // Drop valid and hold until every expected token is out
    task automatic wait_drain();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (expected_tokens.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic set_line(input logic [15:0] value);
        wait_drain();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        line_reg = value;
    endtask

    function automatic logic [7:0] random_letter();
        int r;
        r = $urandom_range(0, 51);
        return (r < 26) ? 8'(CH_UPPER_A + r) : 8'(CH_LOWER_A + (r - 26));
    endfunction

    function automatic logic [7:0] random_number_char();
        int r;
        r = $urandom_range(0, 10);
        return (r == 10) ? CH_DOT : 8'(CH_ZERO + r);
    endfunction

    function automatic logic [7:0] random_text_byte();
        logic [7:0] c;
        do c = 8'($urandom_range(0, 255)); while (c == CH_QUOTE);
        return c;
    endfunction

    function automatic logic [7:0] random_invalid();
        logic [7:0] c;
        do c = 8'($urandom_range(0, 255)); while (byte_class(c) != CLS_INVALID);
        return c;
    endfunction

    task automatic test_directed();
        send_text("+-*/%<=>();");
        // number and identifier boundaries; ';' closes a number with two tokens
        send_text("9a.x7;");
        send_text(" \t\n");
        // identifier closed by a quote, then an empty string
        send_text("b\"\"");
        // string holding a separator, a newline and a high byte
        send_byte(CH_QUOTE);
        send_byte(CH_SEMI);
        send_byte(CH_NEWLINE);
        send_byte(8'hFF);
        send_byte(CH_QUOTE);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h80);
        send_text("@");
    endtask

    task automatic test_line_register();
        set_line(16'hFFFF);
        send_text("k=5;");
        set_line(16'h0000);
        send_text("(x)");
        set_line(16'($urandom_range(0, 65535)));
        send_text("\"s\"7*");
    endtask

    task automatic test_backpressure();
        wait_drain();
        no_idle = 1'b1;
        @(posedge i_clk);
        rx_hold = 200;
        // identifier then operator: two tokens per operator byte, fills the queue fast
        repeat (40) begin
            send_byte(random_letter());
            send_byte(OP_CHARS[8*$urandom_range(0, 7) +: 8]);
        end
        no_idle = 1'b0;
        wait_drain();
        send_text("1+2;");
    endtask

    // Long identifier and long string sent with no gaps
    task automatic test_long_tokens();
        no_idle = 1'b1;
        repeat (LONG_TOKEN) send_byte(random_letter());
        send_byte(CH_SPACE);
        send_byte(CH_QUOTE);
        repeat (LONG_TOKEN) send_byte(random_text_byte());
        send_byte(CH_QUOTE);
        no_idle = 1'b0;
        wait_drain();
    endtask

    task automatic send_random_token();
        int r;
        r = $urandom_range(0, 99);
        if (r < 20) begin
            repeat ($urandom_range(1, 6)) send_byte(random_number_char());
        end else if (r < 40) begin
            repeat ($urandom_range(1, 8)) send_byte(random_letter());
        end else if (r < 52) begin
            send_byte(CH_QUOTE);
            repeat ($urandom_range(0, 6)) send_byte(random_text_byte());
            send_byte(CH_QUOTE);
        end else if (r < 64) begin
            send_byte(OP_CHARS[8*$urandom_range(0, 7) +: 8]);
        end else if (r < 72) begin
            send_byte(SEP_CHARS[8*$urandom_range(0, 2) +: 8]);
        end else if (r < 84) begin
            send_byte(WS_CHARS[8*$urandom_range(0, 2) +: 8]);
        end else if (r < 90) begin
            send_byte(random_invalid());
        end else begin
            // raw noise, may open a string that runs on
            repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
        end
    endtask

    task automatic test_random();
        int goal;
        int phase;
        goal  = sent_items + RANDOM_ITEMS;
        phase = 0;
        while (sent_items < goal) begin
            repeat (60) send_random_token();
            phase++;
            if (phase % 4 == 0)
                set_line((phase % 8 == 0) ? 16'hFFFF : 16'($urandom_range(0, 65535)));
            no_idle = (phase % 3 == 2);
        end
        no_idle = 1'b0;
    endtask

    initial begin
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_wdata   = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_line_register();
        test_backpressure();
        test_long_tokens();
        test_random();
        wait_drain();
        if (mismatches == 0) begin
            $display("** byte_stream_tokenizer: PASSED **");
        end else begin
            $display("** byte_stream_tokenizer: FAILED **");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("** byte_stream_tokenizer: FAILED **");
        $finish;
    end

endmodule

// ===== sim.f =====
design/bst_pkg.sv
design/bst_front.sv
design/bst_queue.sv
design/bst_back.sv
design/byte_stream_tokenizer.sv
sim/byte_stream_tokenizer_tb.sv
